// ===== rtl/fpa_pkg.sv =====
// Package for the fixed-point ALU: request/result structs, opcodes and
// the pipeline word carried between stages. No dependencies.
package fpa_pkg;

    localparam int unsigned FracBitsDef = 8;
    localparam int unsigned DataW       = 32;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_LT      = 4'd4,
        OP_LE      = 4'd5,
        OP_GT      = 4'd6,
        OP_GE      = 4'd7,
        OP_EQ      = 4'd8,
        OP_NE      = 4'd9,
        OP_INC     = 4'd10,
        OP_DEC     = 4'd11,
        OP_TO_INT  = 4'd12,
        OP_FROM_INT = 4'd13
    } t_op;

    typedef struct packed {
        logic        [3:0]       req_type;
        logic signed [DataW-1:0] operand_a;
        logic signed [DataW-1:0] operand_b;
    } t_req;

    typedef struct packed {
        logic signed [DataW-1:0] result_value;
        logic                    compare_true;
        logic                    divide_by_zero;
    } t_res;

    // Word that walks the divider chain with every request.
    typedef struct packed {
        t_op              op;
        logic [DataW-1:0] simple_res;
        logic             cmp;
        logic             dz;
        logic             neg;
        logic [DataW-1:0] mag_a;
        logic [DataW-1:0] mag_b;
        logic [DataW-1:0] rem;
        logic [DataW-1:0] quo;
    } t_pipe;

endpackage

// ===== rtl/fpa_front.sv =====
// Entry stage: decode, simple arithmetic, compares and operand magnitudes.
// Depends on fpa_pkg.
module fpa_front #(
    parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  fpa_pkg::t_req i_req,
    output logic          o_valid,
    output fpa_pkg::t_pipe o_data
);
    import fpa_pkg::*;

    logic             r_valid;
    t_pipe            r_data;
    t_pipe            n_data;
    logic             w_an;
    logic             w_bn;
    logic [DataW-1:0] w_a;
    logic [DataW-1:0] w_b;

    assign w_a  = DataW'(i_req.operand_a);
    assign w_b  = DataW'(i_req.operand_b);
    assign w_an = w_a[DataW-1];
    assign w_bn = w_b[DataW-1];

    always_comb begin
        n_data            = '0;
        n_data.op         = t_op'(i_req.req_type);
        n_data.mag_a      = w_an ? (~w_a + DataW'(1)) : w_a;
        n_data.mag_b      = w_bn ? (~w_b + DataW'(1)) : w_b;
        n_data.neg        = w_an ^ w_bn;
        unique case (t_op'(i_req.req_type))
            OP_ADD:      n_data.simple_res = w_a + w_b;
            OP_SUB:      n_data.simple_res = w_a - w_b;
            OP_DIV:      n_data.dz = (w_b == '0);
            OP_LT:       n_data.cmp = (i_req.operand_a <  i_req.operand_b);
            OP_LE:       n_data.cmp = (i_req.operand_a <= i_req.operand_b);
            OP_GT:       n_data.cmp = (i_req.operand_a >  i_req.operand_b);
            OP_GE:       n_data.cmp = (i_req.operand_a >= i_req.operand_b);
            OP_EQ:       n_data.cmp = (w_a == w_b);
            OP_NE:       n_data.cmp = (w_a != w_b);
            OP_INC:      n_data.simple_res = w_a + DataW'(1);
            OP_DEC:      n_data.simple_res = w_a - DataW'(1);
            OP_TO_INT:   n_data.neg = w_an;
            OP_FROM_INT: n_data.simple_res = w_b << FRAC_BITS;
            default:     n_data.simple_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/fpa_div_stage.sv =====
// One restoring-division step: settles one quotient bit of (|a| << FRAC_BITS) / |b|.
// Depends on fpa_pkg.
module fpa_div_stage #(
    parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDef,
    parameter int unsigned BIT_IDX   = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  fpa_pkg::t_pipe i_data,
    output logic           o_valid,
    output fpa_pkg::t_pipe o_data
);
    import fpa_pkg::*;

    localparam bit          HasBit = (BIT_IDX >= FRAC_BITS);
    localparam int unsigned ABit   = HasBit ? (BIT_IDX - FRAC_BITS) : 0;

    logic             r_valid;
    t_pipe            r_data;
    t_pipe            n_data;
    logic             w_nb;
    logic [DataW:0]   w_part;
    logic [DataW+1:0] w_diff;
    logic             w_ge;

    // Numerator bit comes straight from |a|; low FRAC_BITS bits are zero.
    assign w_nb   = HasBit ? i_data.mag_a[ABit] : 1'b0;
    assign w_part = {i_data.rem, w_nb};
    assign w_diff = {1'b0, w_part} - {2'b00, i_data.mag_b};
    assign w_ge   = ~w_diff[DataW+1];

    always_comb begin
        n_data     = i_data;
        n_data.rem = w_ge ? w_diff[DataW-1:0] : w_part[DataW-1:0];
        n_data.quo = {i_data.quo[DataW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/fpa_back.sv =====
// Exit stages: magnitude multiply, then scale, sign and result select.
// Depends on fpa_pkg.
module fpa_back #(
    parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  fpa_pkg::t_pipe i_data,
    output logic           o_strobe,
    output fpa_pkg::t_res  o_res
);
    import fpa_pkg::*;

    logic                 r_valid1;
    t_op                  r_op;
    logic [DataW-1:0]     r_simple;
    logic                 r_cmp;
    logic                 r_dz;
    logic                 r_neg;
    logic [2*DataW-1:0]   r_prod;
    logic [DataW-1:0]     r_mag;
    logic                 r_strobe;
    t_res                 r_res;
    t_res                 n_res;
    logic [DataW-1:0]     w_mag;
    logic [DataW-1:0]     w_signed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
            r_strobe <= r_valid1;
        end
        r_op     <= i_data.op;
        r_simple <= i_data.simple_res;
        r_cmp    <= i_data.cmp;
        r_dz     <= i_data.dz;
        r_neg    <= i_data.neg;
        r_prod   <= {{DataW{1'b0}}, i_data.mag_a} * {{DataW{1'b0}}, i_data.mag_b};
        r_mag    <= (i_data.op == OP_DIV) ? i_data.quo : (i_data.mag_a >> FRAC_BITS);
        r_res    <= n_res;
    end

    assign w_mag    = (r_op == OP_MUL) ? DataW'(r_prod >> FRAC_BITS) : r_mag;
    assign w_signed = r_neg ? (~w_mag + DataW'(1)) : w_mag;

    always_comb begin
        n_res                = '0;
        n_res.compare_true   = r_cmp;
        n_res.divide_by_zero = r_dz;
        case (r_op) inside
            OP_MUL, OP_TO_INT: n_res.result_value = w_signed;
            OP_DIV:            n_res.result_value = r_dz ? '0 : w_signed;
            default:           n_res.result_value = r_simple;
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

// ===== rtl/fixed_point_alu_core.sv =====
// Top level of the pipelined fixed-point ALU.
// Depends on fpa_pkg, fpa_front, fpa_div_stage and fpa_back.
//
// Usage:
//   Drive i_req and raise start; the request is taken at the clock edge
//   where start is high (busy is always low, so every cycle may carry a
//   new request). Each request gives exactly one result on o_res, marked
//   by o_strobe for a single cycle; the receiver must take it then.
//   Every operation takes the same path through all stages, so results
//   leave in request order. Throughput is one request per cycle.
//   The pipeline has one stage per quotient bit of the (32 + FRAC_BITS)-bit
//   numerator, plus one entry stage and two exit stages (multiplier, then
//   scale/sign/select).
//   Reset (synchronous, active low) clears all stage valid bits; requests
//   in flight are dropped and no strobe follows until new requests enter.
module fixed_point_alu_core #(
    parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  fpa_pkg::t_req i_req,
    output logic          o_strobe,
    output fpa_pkg::t_res o_res
);
    import fpa_pkg::*;

    localparam int unsigned NumW    = DataW + FRAC_BITS;
    localparam int unsigned Latency = NumW + 3;

    logic  w_v [0:NumW];
    t_pipe w_d [0:NumW];

    assign busy = 1'b0;

    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_req   (i_req),
        .o_valid (w_v[0]),
        .o_data  (w_d[0])
    );

    for (genvar k = 0; k < NumW; k++) begin : g_div
        fpa_div_stage #(
            .FRAC_BITS (FRAC_BITS),
            .BIT_IDX   (NumW - 1 - k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .i_data  (w_d[k]),
            .o_valid (w_v[k+1]),
            .o_data  (w_d[k+1])
        );
    end

    fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_v[NumW]),
        .i_data   (w_d[NumW]),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

`ifndef SYNTHESIS
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##Latency o_strobe)
        else $error("request did not produce a result at the pipeline latency");

    a_dz_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.divide_by_zero) |-> (o_res.result_value == '0 &&
            !o_res.compare_true))
        else $error("divide by zero with nonzero result");

    a_cmp_only : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.compare_true) |-> (o_res.result_value == '0))
        else $error("compare result with nonzero value");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for fixed_point_alu_core: random and directed requests, results
// predicted in a scoreboard class. Depends on fpa_pkg and the core RTL.
module tb;
    import fpa_pkg::*;

    localparam int unsigned FRAC = FracBitsDef;
    localparam int LATENCY = FRAC + 35;
    localparam int CYCLE_LIMIT = 200000;

    class alu_scoreboard;
        t_res pending[$];
        int errors;

        function t_res compute(t_req r);
            t_res e;
            logic [31:0] a, b, ma, mb, q;
            logic [63:0] p, n;
            logic neg;
            a = r.operand_a;
            b = r.operand_b;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            neg = a[31] ^ b[31];
            e = '0;
            case (r.req_type)
                OP_ADD: e.result_value = a + b;
                OP_SUB: e.result_value = a - b;
                OP_MUL: begin
                    p = {32'd0, ma} * {32'd0, mb};
                    p = p >> FRAC;
                    e.result_value = neg ? -p[31:0] : p[31:0];
                end
                OP_DIV: begin
                    if (b == 0) begin
                        e.divide_by_zero = 1'b1;
                    end else begin
                        n = {32'd0, ma} << FRAC;
                        p = n / {32'd0, mb};
                        q = p[31:0];
                        e.result_value = neg ? -q : q;
                    end
                end
                OP_LT: e.compare_true = $signed(a) < $signed(b);
                OP_LE: e.compare_true = $signed(a) <= $signed(b);
                OP_GT: e.compare_true = $signed(a) > $signed(b);
                OP_GE: e.compare_true = $signed(a) >= $signed(b);
                OP_EQ: e.compare_true = a == b;
                OP_NE: e.compare_true = a != b;
                OP_INC: e.result_value = a + 1;
                OP_DEC: e.result_value = a - 1;
                OP_TO_INT: begin
                    q = ma >> FRAC;
                    e.result_value = a[31] ? -q : q;
                end
                OP_FROM_INT: e.result_value = b << FRAC;
                default: e = '0;
            endcase
            return e;
        endfunction

        function void note_request(t_req r);
            pending.push_back(compute(r));
        endfunction

        function void check_result(t_res got);
            t_res e;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing pending: expected none actual %h",
                         $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.result_value !== e.result_value) begin
                $display("%0t: result_value expected %h actual %h",
                         $time, e.result_value, got.result_value);
                errors++;
            end
            if (got.compare_true !== e.compare_true) begin
                $display("%0t: compare_true expected %b actual %b",
                         $time, e.compare_true, got.compare_true);
                errors++;
            end
            if (got.divide_by_zero !== e.divide_by_zero) begin
                $display("%0t: divide_by_zero expected %b actual %b",
                         $time, e.divide_by_zero, got.divide_by_zero);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_strobe;
    t_res o_res;

    alu_scoreboard sb;
    int cycles = 0;
    int idle_pct;
    int requests;

    fixed_point_alu_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_strobe(o_strobe), .o_res(o_res)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && start && !busy) sb.note_request(i_req);
        if (i_rst_n && o_strobe) sb.check_result(o_res);
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'd1;
            4: return $signed($urandom_range(0, 4095)) - 2048;
            5: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    // Hold the request until it is taken; idle randomly first.
    task automatic send(logic [3:0] op, logic [31:0] a, logic [31:0] b);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= '{req_type: op, operand_a: a, operand_b: b};
        requests++;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [3:0] op;
        sb = new();
        requests = 0;
        idle_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every op on extremes, unused selectors, divide by zero
        for (int k = 0; k < 16; k++) begin
            send(k[3:0], 32'h8000_0000, 32'h7fff_ffff);
        end
        send(OP_DIV, 32'h0000_0100, 32'd0);
        send(OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
        send(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send(OP_TO_INT, 32'hffff_ff01, 32'd0);
        send(OP_FROM_INT, 32'd0, 32'hffff_ffff);
        send(OP_INC, 32'h7fff_ffff, 32'd0);
        send(OP_DEC, 32'h8000_0000, 32'd0);
        send(OP_EQ, 32'h1234_5678, 32'h1234_5678);
        // pause until everything is back
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: idle_pct = 0;
                1: idle_pct = 61;
                2: idle_pct = 28;
                default: idle_pct = 0;
            endcase
            for (int i = 0; i < 132; i++) begin
                op = 4'($urandom_range(0, 15));
                send(op, pick_operand(), ($urandom_range(0, 9) == 0) ? 32'd0
                                                                     : pick_operand());
            end
        end
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Sent %0d requests over all opcodes, idle levels 0/61/28 percent.",
                 requests);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
